// File: rtl/djb_pkg.sv
// Shared types and constants for the triple-seed djb2 index block.
// Used by every module under rtl; depends on nothing.
package djb_pkg;

   // accumulator width default and lane count
   localparam int ACC_WIDTH_DEF = 64;
   localparam int NUM_LANES     = 3;
   localparam int IDX_W         = 32;
   localparam int KEY_W         = 8;
   localparam int CSR_W         = 32;
   localparam int QUEUE_DEPTH   = 2;

   // reset values of the configuration registers
   localparam logic [CSR_W-1:0] RST_SLOT_COUNT  = 32'd1024;
   localparam logic [CSR_W-1:0] RST_SEED_FIRST  = 32'd5381;
   localparam logic [CSR_W-1:0] RST_SEED_SECOND = 32'd7963;
   localparam logic [CSR_W-1:0] RST_SEED_THIRD  = 32'd9157;

   // djb2 multiplier 33 is a shift by this plus the value itself
   localparam int MIX_SHIFT = 5;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SLOT_COUNT  = 2'd0,
      CSR_SEED_FIRST  = 2'd1,
      CSR_SEED_SECOND = 2'd2,
      CSR_SEED_THIRD  = 2'd3
   } csr_index_type;

   // queue status seen by the producer and the consumer
   typedef struct packed {
      logic not_empty;
      logic not_full;
   } qstat_type;

endpackage

// File: rtl/djb_front.sv
// Front end: takes key bytes and runs the three djb2 accumulators.
// Pushes the finished accumulators on a terminator; uses djb_pkg.
module djb_front import djb_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [KEY_W-1:0]                     req_tdata,
   input  logic [CSR_W-1:0]                     seed_first,
   input  logic [CSR_W-1:0]                     seed_second,
   input  logic [CSR_W-1:0]                     seed_third,
   input  qstat_type                            q_stat,
   output logic                                 push_valid,
   output logic [NUM_LANES-1:0][ACC_WIDTH-1:0]  push_data
);

   logic [NUM_LANES-1:0][ACC_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_LANES-1:0][ACC_WIDTH-1:0] seeds;
   logic [ACC_WIDTH-1:0]                addend;
   logic                                accept;
   logic                                is_term;

   assign req_tready = q_stat.not_full;
   assign accept     = req_tvalid && req_tready;
   assign is_term    = (req_tdata == '0);
   assign push_valid = accept && is_term;
   assign push_data  = acc_ff;

   // widen the seeds and sign-extend the byte
   assign seeds[0] = ACC_WIDTH'(seed_first);
   assign seeds[1] = ACC_WIDTH'(seed_second);
   assign seeds[2] = ACC_WIDTH'(seed_third);
   assign addend   = {{(ACC_WIDTH-KEY_W){req_tdata[KEY_W-1]}}, req_tdata};

   // mix each lane on a data byte, reload on a terminator
   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            if (is_term) begin
               acc_in[i] = seeds[i];
            end else begin
               acc_in[i] = (acc_ff[i] << MIX_SHIFT) + acc_ff[i] + addend;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= ACC_WIDTH'(RST_SEED_FIRST);
         acc_ff[1] <= ACC_WIDTH'(RST_SEED_SECOND);
         acc_ff[2] <= ACC_WIDTH'(RST_SEED_THIRD);
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

// File: rtl/djb_queue.sv
// Short queue of finished accumulator sets between front and back end.
// Uses djb_pkg for depth, lane count and the status struct.
module djb_queue import djb_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  logic [NUM_LANES-1:0][ACC_WIDTH-1:0]  push_data,
   input  logic                                 pop,
   output logic [NUM_LANES-1:0][ACC_WIDTH-1:0]  pop_data,
   output qstat_type                            q_stat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [NUM_LANES-1:0][ACC_WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]                    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic                                do_push, do_pop;

   assign q_stat.not_empty = (count_ff != '0);
   assign q_stat.not_full  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign do_push          = push && q_stat.not_full;
   assign do_pop           = pop && q_stat.not_empty;
   assign pop_data         = mem_ff[rd_ptr_ff];

   // advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/djb_mod.sv
// Back end: reduces three accumulators modulo the table size, one
// dividend bit per cycle in each lane, and holds the result; uses djb_pkg.
module djb_mod import djb_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  qstat_type                            q_stat,
   input  logic [NUM_LANES-1:0][ACC_WIDTH-1:0]  pop_data,
   output logic                                 pop,
   input  logic [CSR_W-1:0]                     slot_count,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [NUM_LANES*IDX_W-1:0]           rsp_tdata
);

   localparam int CNT_W = (ACC_WIDTH > 1) ? $clog2(ACC_WIDTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   state_type                           state_ff, state_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic [NUM_LANES-1:0][ACC_WIDTH-1:0] dvd_ff, dvd_in;
   logic [NUM_LANES-1:0][IDX_W-1:0]     rem_ff, rem_in;
   logic [NUM_LANES-1:0][IDX_W-1:0]     step_rem;
   logic [IDX_W-1:0]                    div_ff, div_in;
   logic [NUM_LANES*IDX_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [IDX_W:0]                      trial [NUM_LANES];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign pop        = (state_ff == ST_IDLE) && q_stat.not_empty;

   // one restoring step per lane: shift in the next bit, subtract if it fits
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         trial[i] = {rem_ff[i], dvd_ff[i][ACC_WIDTH-1]};
         if (trial[i] >= {1'b0, div_ff}) begin
            step_rem[i] = IDX_W'(trial[i] - {1'b0, div_ff});
         end else begin
            step_rem[i] = trial[i][IDX_W-1:0];
         end
      end
   end

   // sequence load, iterate and hand over
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_stat.not_empty) begin
               dvd_in   = pop_data;
               rem_in   = '0;
               div_in   = slot_count;
               cnt_in   = CNT_W'(ACC_WIDTH - 1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            for (int i = 0; i < NUM_LANES; i++) begin
               dvd_in[i] = dvd_ff[i] << 1;
            end
            rem_in = step_rem;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // zero table size yields zero indices
               rsp_data_in  = (div_ff == '0) ? '0 : step_rem;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff      <= cnt_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/triple_seed_djb2_index.sv
// Top level of the triple-seed djb2 index block: configuration registers,
// front end, queue and modulo back end; uses djb_pkg and all djb_ modules.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_tvalid/req_tready | tdata[7:0] key_byte
//   rsp     | out | rsp_tvalid/rsp_tready | tdata index_first/second/third
//   csr     | in  | csr_wr_en             | csr_index, csr_wdata
//
// Key bytes are taken one per cycle.
// A zero byte queues the three sums; the restoring remainder unit, one lane
// per sum, then reduces each sum to its index one bit per cycle.
// The front end stalls only while the two-entry queue is full.
// Reset is synchronous and restores the register defaults and seeds.
module triple_seed_djb2_index import djb_pkg::*; #(
   parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [KEY_W-1:0]            req_tdata,   // [7:0] key_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] index_first, [63:32] index_second, [95:64] index_third
   output logic [NUM_LANES*IDX_W-1:0]  rsp_tdata,
   input  logic                        csr_wr_en,
   input  logic [1:0]                  csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   logic [CSR_W-1:0]                    slot_count_ff;
   logic [CSR_W-1:0]                    seed_first_ff;
   logic [CSR_W-1:0]                    seed_second_ff;
   logic [CSR_W-1:0]                    seed_third_ff;
   qstat_type                           q_stat;
   logic                                push_valid;
   logic                                pop;
   logic [NUM_LANES-1:0][ACC_WIDTH-1:0] push_data;
   logic [NUM_LANES-1:0][ACC_WIDTH-1:0] pop_data;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff  <= RST_SLOT_COUNT;
         seed_first_ff  <= RST_SEED_FIRST;
         seed_second_ff <= RST_SEED_SECOND;
         seed_third_ff  <= RST_SEED_THIRD;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_SLOT_COUNT:  slot_count_ff  <= csr_wdata;
            CSR_SEED_FIRST:  seed_first_ff  <= csr_wdata;
            CSR_SEED_SECOND: seed_second_ff <= csr_wdata;
            CSR_SEED_THIRD:  seed_third_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   djb_front #(.ACC_WIDTH(ACC_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .seed_first  (seed_first_ff),
      .seed_second (seed_second_ff),
      .seed_third  (seed_third_ff),
      .q_stat      (q_stat),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   djb_queue #(.ACC_WIDTH(ACC_WIDTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   djb_mod #(.ACC_WIDTH(ACC_WIDTH)) u_mod (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .pop_data   (pop_data),
      .pop        (pop),
      .slot_count (slot_count_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // a terminator never arrives while the queue is full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> q_stat.not_full)
      else $error("terminator pushed into a full queue");

   // the back end only pops what is there
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.not_empty)
      else $error("pop from an empty queue");

   // every index lies below a nonzero table size
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && slot_count_ff != '0) |->
         (rsp_tdata[IDX_W-1:0] < slot_count_ff &&
          rsp_tdata[2*IDX_W-1:IDX_W] < slot_count_ff &&
          rsp_tdata[3*IDX_W-1:2*IDX_W] < slot_count_ff))
      else $error("index not below table size");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
